// File: sv/x2s8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x2s8_pkg
// Shared constants, matrix coefficients and threshold function for the
// XYZ to 8-bit sRGB encoder.
// ----------------------------------------------------------------------------
package x2s8_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_BITS     = 20;
  localparam int IN_W          = 24;
  localparam int COEF_W        = 23;
  localparam int PROD_W        = IN_W + COEF_W;
  localparam int SUM_W         = PROD_W + 2;
  localparam int CH_W          = 27;
  localparam int DIV_W         = CH_W - 1;
  localparam int CODE_W        = 8;
  localparam int ENC_STAGES    = 8;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_SPACE = 1'd1;

  // XYZ to linear sRGB, 20 fraction bits
  localparam logic signed [COEF_W-1:0] COEF [3][3] = '{
    '{ 23'sd3397863, -23'sd1611807, -23'sd522748 },
    '{-23'sd1016349,  23'sd1967140,  23'sd43575  },
    '{ 23'sd58346,   -23'sd213937,   23'sd1108581}
  };

  // Smallest v with v^5 * 53805^12 >= (200k + 2705)^12 * 2^(5f)
  function automatic logic [20:0] curve_thr(input int k, input int f);
    logic [299:0] rhs;
    logic [299:0] lhs;
    logic [21:0]  lo;
    logic [21:0]  hi;
    logic [21:0]  mid;
    rhs = 300'd1;
    for (int i = 0; i < 12; i++) rhs = rhs * 300'(200 * k + 2705);
    rhs = rhs << (5 * f);
    lo = '0;
    hi = 22'((64'd1 << f) + 64'd1);
    for (int n = 0; n < 24; n++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        lhs = 300'd1;
        for (int i = 0; i < 5; i++) lhs = lhs * 300'(mid);
        for (int i = 0; i < 12; i++) lhs = lhs * 300'd53805;
        if (lhs >= rhs) hi = mid;
        else lo = mid + 22'd1;
      end
    end
    return lo[20:0];
  endfunction

endpackage

// File: sv/x2s8_divide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x2s8_divide
// Pipelined restoring divider, one quotient bit per stage, giving the
// normalized channel value or the pass value when no scaling is needed.
// ----------------------------------------------------------------------------
module x2s8_divide #(
  parameter int FRAC_BITS = x2s8_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      ce,
  input  logic [x2s8_pkg::DIV_W-1:0] dvd,
  input  logic [x2s8_pkg::DIV_W-1:0] dvs,
  input  logic [FRAC_BITS:0]        pass,
  input  logic                      norm,
  output logic [FRAC_BITS:0]        v_out
);
  import x2s8_pkg::*;

  localparam int NST = FRAC_BITS + 1;

  logic [DIV_W-1:0]   rem_r  [NST-1];
  logic [FRAC_BITS:0] quo_r  [NST-1];
  logic [DIV_W-1:0]   dvs_r  [NST-1];
  logic [FRAC_BITS:0] pass_r [NST-1];
  logic               norm_r [NST-1];
  logic [FRAC_BITS:0] v_r;

  for (genvar j = 0; j < NST; j++) begin : g_st
    logic [DIV_W:0]     trial;
    logic [DIV_W-1:0]   d_in;
    logic [FRAC_BITS:0] q_in;
    logic [FRAC_BITS:0] pass_in;
    logic               norm_in;
    logic               ge;
    logic [FRAC_BITS:0] q_nxt;
    logic [DIV_W-1:0]   rem_nxt;

    if (j == 0) begin : g_first
      assign trial   = {1'b0, dvd};
      assign d_in    = dvs;
      assign q_in    = '0;
      assign pass_in = pass;
      assign norm_in = norm;
    end else begin : g_next
      assign trial   = {rem_r[j-1], 1'b0};
      assign d_in    = dvs_r[j-1];
      assign q_in    = quo_r[j-1];
      assign pass_in = pass_r[j-1];
      assign norm_in = norm_r[j-1];
    end

    assign ge      = trial >= {1'b0, d_in};
    assign q_nxt   = {q_in[FRAC_BITS-1:0], ge};
    assign rem_nxt = ge ? DIV_W'(trial - {1'b0, d_in}) : DIV_W'(trial);

    if (j < NST - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_r[j]  <= rem_nxt;
          quo_r[j]  <= q_nxt;
          dvs_r[j]  <= d_in;
          pass_r[j] <= pass_in;
          norm_r[j] <= norm_in;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (ce) v_r <= norm_in ? q_nxt : pass_in;
      end
    end
  end

  assign v_out = v_r;

endmodule

// File: sv/x2s8_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x2s8_encode
// Eight-stage encoder: pipelined search of the sRGB curve thresholds, the
// linear toe segment and plain linear scaling, selected at the last stage.
// ----------------------------------------------------------------------------
module x2s8_encode #(
  parameter int FRAC_BITS = x2s8_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       ce,
  input  logic                       mode,
  input  logic [FRAC_BITS:0]         v_in,
  output logic [x2s8_pkg::CODE_W-1:0] code_out
);
  import x2s8_pkg::*;

  localparam int LAST = ENC_STAGES - 1;
  localparam int PW   = FRAC_BITS + 17;
  localparam logic [FRAC_BITS:0] LIN_LIM =
    (FRAC_BITS + 1)'((64'd31308 << FRAC_BITS) / 64'd10000000);
  localparam logic [PW-1:0] TOE_BIAS = PW'(64'd5 << FRAC_BITS);
  localparam logic [FRAC_BITS+8:0] HALF = (FRAC_BITS + 9)'(64'd1 << (FRAC_BITS - 1));

  logic [FRAC_BITS:0]  thr [256];
  logic [FRAC_BITS:0]  v_r    [LAST];
  logic [CODE_W-1:0]   code_r [LAST];
  logic [CODE_W-1:0]   lin_r  [LAST];
  logic                seg_r  [LAST];
  logic [CODE_W-1:0]   toe_r  [1:LAST-1];
  logic [PW-1:0]       prod_r;
  logic [CODE_W-1:0]   out_r;
  logic [FRAC_BITS+8:0] lin_sum;
  logic [PW-1:0]       toe_sum;
  logic [CODE_W-1:0]   toe_t;
  logic [15:0]         toe_q;
  logic [CODE_W-1:0]   fin_cand;
  logic [CODE_W-1:0]   fin_curve;

  assign thr[0] = '0;
  for (genvar k = 1; k < 256; k++) begin : g_thr
    localparam logic [20:0] T = curve_thr(k, FRAC_BITS);
    assign thr[k] = T[FRAC_BITS:0];
  end

  assign lin_sum = ({v_in, 8'd0} - (FRAC_BITS + 9)'(v_in)) + HALF;
  assign toe_sum = prod_r + TOE_BIAS;
  assign toe_t   = toe_sum[FRAC_BITS +: CODE_W];
  assign toe_q   = 16'(toe_t) * 16'd205;

  always_ff @(posedge clk) begin
    if (ce) prod_r <= PW'(v_in) * PW'(32946);
  end

  for (genvar e = 0; e < LAST; e++) begin : g_st
    logic [FRAC_BITS:0] v_cur;
    logic [CODE_W-1:0]  c_prev;
    logic [CODE_W-1:0]  l_cur;
    logic               s_cur;
    logic [CODE_W-1:0]  cand;

    if (e == 0) begin : g_first
      assign v_cur  = v_in;
      assign c_prev = '0;
      assign l_cur  = lin_sum[FRAC_BITS +: CODE_W];
      assign s_cur  = v_in <= LIN_LIM;
    end else begin : g_next
      assign v_cur  = v_r[e-1];
      assign c_prev = code_r[e-1];
      assign l_cur  = lin_r[e-1];
      assign s_cur  = seg_r[e-1];
    end
    assign cand = c_prev | (CODE_W'(8'h80) >> e);

    always_ff @(posedge clk) begin
      if (ce) begin
        v_r[e]    <= v_cur;
        code_r[e] <= (v_cur >= thr[cand]) ? cand : c_prev;
        lin_r[e]  <= l_cur;
        seg_r[e]  <= s_cur;
      end
    end

    if (e == 1) begin : g_toe
      always_ff @(posedge clk) begin
        if (ce) toe_r[e] <= CODE_W'(toe_q >> 11);
      end
    end else if (e > 1) begin : g_toe_d
      always_ff @(posedge clk) begin
        if (ce) toe_r[e] <= toe_r[e-1];
      end
    end
  end

  assign fin_cand  = code_r[LAST-1] | CODE_W'(1);
  assign fin_curve = (v_r[LAST-1] >= thr[fin_cand]) ? fin_cand : code_r[LAST-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      if (mode) out_r <= lin_r[LAST-1];
      else if (seg_r[LAST-1]) out_r <= toe_r[LAST-1];
      else out_r <= fin_curve;
    end
  end

  assign code_out = out_r;

endmodule

// File: sv/xyz_to_srgb8_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xyz_to_srgb8_encode
// Converts XYZ or linear RGB pixels (24-bit signed, FRAC_BITS fraction bits)
// into 8-bit sRGB or linearly scaled RGB codes.
//
// Usage:
//   in_*  : one pixel per transfer, in_tdata = {comp_third, comp_second,
//           comp_first}, 24 bits each, first component in the low bits.
//   out_* : one result per pixel, out_tdata = {blue, green, red} codes.
//   cfg_* : register 0 encode_mode, register 1 input_space; write only
//           while no pixel is in flight.
//   Throughput is one pixel per cycle while in_tready is high. The pipeline
//   holds two matrix stages, a max stage, one divider stage per quotient
//   bit, eight encode stages and the output register.
//   The pipeline advances as a whole; a two-entry output buffer absorbs a
//   receiver stall, and in_tready drops only while that buffer is full.
//   Reset (rst_n low, synchronous) empties the pipeline and clears both
//   registers to 0 (sRGB curve, XYZ input).
// ----------------------------------------------------------------------------
module xyz_to_srgb8_encode #(
  parameter int FRAC_BITS = x2s8_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // comp_first, comp_second, comp_third
  input  logic [3*x2s8_pkg::IN_W-1:0]     in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // red_code, green_code, blue_code
  output logic [3*x2s8_pkg::CODE_W-1:0]   out_tdata,
  input  logic                            cfg_we,
  input  logic [x2s8_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [0:0]                      cfg_wdata
);
  import x2s8_pkg::*;

  localparam int NS = 3 + (FRAC_BITS + 1) + ENC_STAGES;
  localparam logic signed [CH_W-1:0] ONE = CH_W'(64'd1 << FRAC_BITS);

  logic                      encode_mode_r;
  logic                      input_space_r;
  logic [NS-1:0]             vld_r;
  logic                      ce;

  logic signed [IN_W-1:0]    in_comp [3];
  logic signed [IN_W-1:0]    comp_r  [3];
  logic signed [PROD_W-1:0]  prod_r  [3][3];
  logic signed [SUM_W-1:0]   sum     [3];
  logic signed [CH_W-1:0]    ch_nxt  [3];
  logic signed [CH_W-1:0]    ch_r    [3];
  logic signed [CH_W-1:0]    mx;
  logic [DIV_W-1:0]          dvd_r   [3];
  logic [DIV_W-1:0]          dvs_r;
  logic [FRAC_BITS:0]        pass_r  [3];
  logic                      norm_r;
  logic [FRAC_BITS:0]        v       [3];
  logic [CODE_W-1:0]         code    [3];
  logic [3*CODE_W-1:0]       res;

  logic                      out_vld_r;
  logic [3*CODE_W-1:0]       out_dat_r;
  logic                      skd_vld_r;
  logic [3*CODE_W-1:0]       skd_dat_r;
  logic                      push;
  logic                      pop;

  assign ce        = !skd_vld_r;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      encode_mode_r <= 1'b0;
      input_space_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENCODE_MODE: encode_mode_r <= cfg_wdata[0];
        CFG_INPUT_SPACE: input_space_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (ce) vld_r <= {vld_r[NS-2:0], in_tvalid};
  end

  // matrix products
  always_comb begin
    for (int i = 0; i < 3; i++) in_comp[i] = in_tdata[i*IN_W +: IN_W];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        comp_r[i] <= in_comp[i];
        for (int j = 0; j < 3; j++) prod_r[i][j] <= in_comp[j] * COEF[i][j];
      end
    end
  end

  // row sums, floored to the fixed-point grid, or the raw components when input_space is set
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM_W'(prod_r[i][0]) + SUM_W'(prod_r[i][1]) + SUM_W'(prod_r[i][2]);
      ch_nxt[i] = input_space_r ? CH_W'(comp_r[i]) : CH_W'(sum[i] >>> COEF_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) ch_r[i] <= ch_nxt[i];
    end
  end

  // max and normalization setup
  always_comb begin
    mx = ch_r[0];
    if (ch_r[1] > mx) mx = ch_r[1];
    if (ch_r[2] > mx) mx = ch_r[2];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      norm_r <= mx > ONE;
      dvs_r  <= mx[DIV_W-1:0];
      for (int i = 0; i < 3; i++) begin
        dvd_r[i]  <= (ch_r[i] > 0) ? ch_r[i][DIV_W-1:0] : '0;
        pass_r[i] <= (ch_r[i] > 0) ? ch_r[i][FRAC_BITS:0] : '0;
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    x2s8_divide #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk   (clk),
      .ce    (ce),
      .dvd   (dvd_r[c]),
      .dvs   (dvs_r),
      .pass  (pass_r[c]),
      .norm  (norm_r),
      .v_out (v[c])
    );

    x2s8_encode #(.FRAC_BITS(FRAC_BITS)) u_enc (
      .clk      (clk),
      .ce       (ce),
      .mode     (encode_mode_r),
      .v_in     (v[c]),
      .code_out (code[c])
    );

    assign res[c*CODE_W +: CODE_W] = code[c];
  end

  // two-entry output buffer
  assign push = ce && vld_r[NS-1];
  assign pop  = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      skd_vld_r <= 1'b0;
    end else if (out_vld_r && !pop) begin
      if (push) skd_vld_r <= 1'b1;
    end else if (skd_vld_r) begin
      out_vld_r <= 1'b1;
      skd_vld_r <= 1'b0;
    end else begin
      out_vld_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !pop) begin
      if (push) skd_dat_r <= res;
    end else if (skd_vld_r) begin
      out_dat_r <= skd_dat_r;
    end else if (push) begin
      out_dat_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

endmodule
